// ----- src/rb2d_pkg.sv -----
// Shared types, command codes and fixed-point helpers for the 2D rigid body integrator.
// No dependencies.
package rb2d_pkg;

    typedef enum logic [3:0] {
        CMD_FORCE      = 4'd0,
        CMD_FORCE_AT   = 4'd1,
        CMD_TORQUE     = 4'd2,
        CMD_IMPULSE    = 4'd3,
        CMD_IMPULSE_AT = 4'd4,
        CMD_STEP       = 4'd5,
        CMD_INIT_POSE  = 4'd6,
        CMD_INIT_VEL   = 4'd7,
        CMD_RESET      = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        REG_INV_MASS    = 3'd0,
        REG_INV_INERTIA = 3'd1,
        REG_GRAV_EN     = 3'd2,
        REG_GRAV_X      = 3'd3,
        REG_GRAV_Y      = 3'd4,
        REG_WORLD_W     = 3'd5,
        REG_WORLD_H     = 3'd6
    } reg_idx_t;

    // Multiplier operand select codes.
    typedef enum logic [3:0] {
        MA_RX, MA_RY, MA_VX, MA_VY, MA_TORQ, MA_FX, MA_FY, MA_MOM,
        MA_ACCX, MA_ACCY, MA_ACCA, MA_VELX, MA_VELY, MA_VELA
    } mula_t;

    typedef enum logic [2:0] {
        MB_VX, MB_VY, MB_IMASS, MB_IINER, MB_DT
    } mulb_t;

    // Destination of a rounded product.
    typedef enum logic [3:0] {
        D_NONE, D_T0, D_T1, D_ACCX, D_ACCY, D_ACCA, D_KX, D_KY, D_KA,
        D_VX_ADD, D_VY_ADD, D_VA_ADD, D_PX_ADD, D_PY_ADD, D_PA_ADD
    } dst_t;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_TORQ, S_KICK1, S_KICK2, S_WALL, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE, OP_LATCH, OP_SIMPLE, OP_R, OP_TORQ_SUM, OP_KICK, OP_WALL
    } op_t;

    typedef struct packed {
        op_t    op;
        logic   mul_go;
        mula_t  mula;
        mulb_t  mulb;
        logic   shift17;
        dst_t   dst;
        logic   out_load;
    } rb2d_cmd_t;

    typedef struct packed {
        cmd_t   cmd;
        logic   mass_nz;
        logic   iner_nz;
        logic   mul_done;
    } rb2d_stat_t;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'sh07FFFFFFF) return 32'sh7FFFFFFF;
        if (s < -33'sh080000000) return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) - 33'(b);
        if (s > 33'sh07FFFFFFF) return 32'sh7FFFFFFF;
        if (s < -33'sh080000000) return 32'sh80000000;
        return s[31:0];
    endfunction

endpackage

// ----- src/rigid_body_2d_integrator.sv -----
// Top level of the 2D rigid body integrator (velocity Verlet, Q16.16).
// Simple commands use no multiply; an impulse uses two, or none with zero inverse mass;
// force at a point uses two, impulse at a point two to five, and a step nine.
// One request at a time; each multiply holds the shared unit until its product returns.
// A waiting result does not block the input; the next result waits in the sequencer for it.
// Reset (aresetn low, synchronous) clears registers, body state and handshakes.
// Depends on rb2d_pkg, rb2d_ctrl, rb2d_dp and rb2d_mul.
module rigid_body_2d_integrator import rb2d_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[3:0], vec_x[35:4], vec_y[67:36], point_x[99:68], point_y[131:100],
    // scalar[163:132], zero fill to 168 bits
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, angle, vel_x, vel_y, vel_angle, 32 bits each from bit 0
    output logic [191:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    rb2d_cmd_t  cmd;
    rb2d_stat_t stat;

    // Configuration writes are always taken; the user must send them only while idle, as the block does not enforce it.
    assign cfg_ready = 1'b1;

    rb2d_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .stat(stat), .cmd(cmd)
    );

    rb2d_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid && cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .s_data(s_tdata[163:0]),
        .cmd(cmd), .stat(stat), .m_data(m_tdata)
    );
endmodule

// ----- src/rb2d_mul.sv -----
// Shared signed 32x32 multiplier with round-half-away and saturation, two stages.
// Depends on rb2d_pkg.
module rb2d_mul import rb2d_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               go,
    input  logic               shift17,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic               done,
    output logic signed [31:0] q
);
    logic signed [63:0] p_reg;
    logic               sh_reg, v1_reg, v2_reg;
    logic signed [31:0] q_reg;
    logic        [63:0] mag, rnd;
    logic               neg;
    logic signed [31:0] q_next;

    always_comb begin
        neg = p_reg[63];
        mag = neg ? (64'd0 - p_reg) : p_reg;
        rnd = sh_reg ? ((mag + 64'd65536) >> 17) : ((mag + 64'd32768) >> 16);
        if (neg) begin
            q_next = (rnd >= 64'h80000000) ? 32'sh80000000 : 32'(64'd0 - rnd);
        end else begin
            q_next = (rnd > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : rnd[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        p_reg  <= a * b;
        sh_reg <= shift17;
        q_reg  <= q_next;
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= go;
            v2_reg <= v1_reg;
        end
    end

    assign done = v2_reg;
    assign q    = q_reg;
endmodule

// ----- src/rb2d_ctrl.sv -----
// Command sequencer for the 2D rigid body integrator; issues multiplies one at a time.
// Depends on rb2d_pkg.
module rb2d_ctrl import rb2d_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  rb2d_stat_t stat,
    output rb2d_cmd_t  cmd
);
    state_t state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic       wait_reg, wait_next;
    logic       ov_reg, ov_next;

    // Step program: acc (3), kick (3), v+=k at the start of S_KICK2, pose (3), v+=k, walls.
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        wait_next  = wait_reg;
        ov_next    = ov_reg;
        cmd        = '{op: OP_NONE, mul_go: 1'b0, mula: MA_RX, mulb: MB_VX,
                       shift17: 1'b0, dst: D_NONE, out_load: 1'b0};
        in_ready   = 1'b0;
        if (ov_reg && out_ready) ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid && in_ready) begin
                    cmd.op = OP_LATCH;
                    state_next = S_MUL;
                    idx_next = 4'd0;
                    wait_next = 1'b0;
                end
            end
            S_MUL: begin
                priority case (stat.cmd)
                    CMD_FORCE_AT, CMD_IMPULSE_AT: begin
                        cmd.op = OP_R;
                        state_next = S_TORQ;
                    end
                    CMD_IMPULSE: begin
                        state_next = stat.mass_nz ? S_TORQ : S_OUT;
                        idx_next = 4'd2;
                    end
                    CMD_STEP: begin
                        state_next = S_KICK1;
                    end
                    default: begin
                        cmd.op = OP_SIMPLE;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_TORQ: begin
                // idx 0,1: torque products; 2,3: impulse linear; 4: angular impulse
                if (!wait_reg) begin
                    wait_next = 1'b1;
                    cmd.mul_go = 1'b1;
                    unique case (idx_reg)
                        4'd0: begin cmd.mula = MA_RX; cmd.mulb = MB_VY; cmd.dst = D_T0; end
                        4'd1: begin cmd.mula = MA_RY; cmd.mulb = MB_VX; cmd.dst = D_T1; end
                        4'd2: begin cmd.mula = MA_VX; cmd.mulb = MB_IMASS;
                                    cmd.dst = D_VX_ADD; end
                        4'd3: begin cmd.mula = MA_VY; cmd.mulb = MB_IMASS;
                                    cmd.dst = D_VY_ADD; end
                        default: begin cmd.mula = MA_TORQ; cmd.mulb = MB_IINER;
                                    cmd.dst = D_VA_ADD; end
                    endcase
                end else if (stat.mul_done) begin
                    wait_next = 1'b0;
                    unique case (idx_reg)
                        4'd0: begin cmd.dst = D_T0; idx_next = 4'd1; end
                        4'd1: begin
                            cmd.dst = D_T1;
                            cmd.op  = OP_TORQ_SUM;
                            if (stat.cmd == CMD_FORCE_AT) state_next = S_OUT;
                            else if (stat.mass_nz) idx_next = 4'd2;
                            else if (stat.iner_nz) idx_next = 4'd4;
                            else state_next = S_OUT;
                        end
                        4'd2: begin cmd.dst = D_VX_ADD; idx_next = 4'd3; end
                        4'd3: begin
                            cmd.dst = D_VY_ADD;
                            if (stat.cmd == CMD_IMPULSE_AT && stat.iner_nz) idx_next = 4'd4;
                            else state_next = S_OUT;
                        end
                        default: begin cmd.dst = D_VA_ADD; state_next = S_OUT; end
                    endcase
                end
            end
            S_KICK1: begin
                // idx 0..2 acc, 3..5 kick
                if (!wait_reg) begin
                    wait_next = 1'b1;
                    cmd.mul_go = 1'b1;
                    unique case (idx_reg)
                        4'd0: begin cmd.mula = MA_FX; cmd.mulb = MB_IMASS; cmd.dst = D_ACCX; end
                        4'd1: begin cmd.mula = MA_FY; cmd.mulb = MB_IMASS; cmd.dst = D_ACCY; end
                        4'd2: begin cmd.mula = MA_MOM; cmd.mulb = MB_IINER; cmd.dst = D_ACCA; end
                        4'd3: begin cmd.mula = MA_ACCX; cmd.mulb = MB_DT; cmd.shift17 = 1'b1;
                                    cmd.dst = D_KX; end
                        4'd4: begin cmd.mula = MA_ACCY; cmd.mulb = MB_DT; cmd.shift17 = 1'b1;
                                    cmd.dst = D_KY; end
                        default: begin cmd.mula = MA_ACCA; cmd.mulb = MB_DT;
                                    cmd.shift17 = 1'b1; cmd.dst = D_KA; end
                    endcase
                end else if (stat.mul_done) begin
                    wait_next = 1'b0;
                    unique case (idx_reg)
                        4'd0: cmd.dst = D_ACCX;
                        4'd1: cmd.dst = D_ACCY;
                        4'd2: cmd.dst = D_ACCA;
                        4'd3: cmd.dst = D_KX;
                        4'd4: cmd.dst = D_KY;
                        default: cmd.dst = D_KA;
                    endcase
                    if (idx_reg == 4'd5) begin
                        state_next = S_KICK2;
                        idx_next = 4'd0;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            S_KICK2: begin
                // idx 0 applies the first kick, 1..3 drift products
                if (idx_reg == 4'd0) begin
                    cmd.op = OP_KICK;
                    idx_next = 4'd1;
                end else if (!wait_reg) begin
                    wait_next = 1'b1;
                    cmd.mul_go = 1'b1;
                    cmd.mulb = MB_DT;
                    unique case (idx_reg)
                        4'd1: begin cmd.mula = MA_VELX; cmd.dst = D_PX_ADD; end
                        4'd2: begin cmd.mula = MA_VELY; cmd.dst = D_PY_ADD; end
                        default: begin cmd.mula = MA_VELA; cmd.dst = D_PA_ADD; end
                    endcase
                end else if (stat.mul_done) begin
                    wait_next = 1'b0;
                    unique case (idx_reg)
                        4'd1: cmd.dst = D_PX_ADD;
                        4'd2: cmd.dst = D_PY_ADD;
                        default: cmd.dst = D_PA_ADD;
                    endcase
                    if (idx_reg == 4'd3) state_next = S_WALL;
                    else idx_next = idx_reg + 4'd1;
                end
            end
            S_WALL: begin
                if (idx_reg == 4'd3) begin
                    cmd.op = OP_KICK;
                    idx_next = 4'd4;
                end else begin
                    cmd.op = OP_WALL;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // The result register is loaded once the previous result has left.
                if (!ov_reg || out_ready) begin
                    cmd.out_load = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= 4'd0;
            wait_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            wait_reg  <= wait_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !in_ready)
        else $error("request accepted while busy");
    a_one_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_go |=> !cmd.mul_go)
        else $error("multiplier issued twice");
endmodule

// ----- src/rb2d_dp.sv -----
// Datapath: body state, configuration registers, operand muxing and the shared multiplier.
// Depends on rb2d_pkg and rb2d_mul.
module rb2d_dp import rb2d_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic [163:0] s_data,
    input  rb2d_cmd_t    cmd,
    output rb2d_stat_t   stat,
    output logic [191:0] m_data
);
    logic [30:0] imass_reg, iiner_reg, ww_reg, wh_reg;
    logic        gen_reg;
    logic signed [31:0] gx_reg, gy_reg;
    logic signed [31:0] pos_reg [3], vel_reg [3], pini_reg [3], vini_reg [3];
    logic signed [31:0] fx_reg, fy_reg, mom_reg;
    cmd_t               c_reg;
    logic signed [31:0] vx_reg, vy_reg, px_reg, py_reg, sc_reg;
    logic signed [31:0] rx_reg, ry_reg, t0_reg, torq_reg;
    logic signed [31:0] acc_reg [3], k_reg [3];
    logic [191:0]       out_reg;
    logic signed [31:0] ma, mb, mq;
    logic               mdone;
    cmd_t               in_cmd;
    logic signed [31:0] wall_vx, wall_vy;

    assign in_cmd = cmd_t'(s_data[3:0]);

    always_comb begin
        unique case (cmd.mula)
            MA_RX:   ma = rx_reg;
            MA_RY:   ma = ry_reg;
            MA_VX:   ma = vx_reg;
            MA_VY:   ma = vy_reg;
            MA_TORQ: ma = torq_reg;
            MA_FX:   ma = fx_reg;
            MA_FY:   ma = fy_reg;
            MA_MOM:  ma = mom_reg;
            MA_ACCX: ma = acc_reg[0];
            MA_ACCY: ma = acc_reg[1];
            MA_ACCA: ma = acc_reg[2];
            MA_VELX: ma = vel_reg[0];
            MA_VELY: ma = vel_reg[1];
            MA_VELA: ma = vel_reg[2];
            default: ma = '0;
        endcase
        unique case (cmd.mulb)
            MB_VX:    mb = vx_reg;
            MB_VY:    mb = vy_reg;
            MB_IMASS: mb = {1'b0, imass_reg};
            MB_IINER: mb = {1'b0, iiner_reg};
            MB_DT:    mb = sc_reg;
            default:  mb = '0;
        endcase
    end

    // Wall reflection: the far wall is checked first, then the near wall sees the result.
    // Sitting exactly at zero with a zero-width world, a positive velocity fires both and keeps its sign.
    always_comb begin
        wall_vx = vel_reg[0];
        if (pos_reg[0] >= $signed({1'b0, ww_reg}) && wall_vx > 0) wall_vx = -wall_vx;
        if (pos_reg[0] <= 0 && wall_vx < 0) wall_vx = sat_sub(32'sd0, wall_vx);
        wall_vy = vel_reg[1];
        if (pos_reg[1] >= $signed({1'b0, wh_reg}) && wall_vy > 0) wall_vy = -wall_vy;
        if (pos_reg[1] <= 0 && wall_vy < 0) wall_vy = sat_sub(32'sd0, wall_vy);
    end

    rb2d_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .go(cmd.mul_go), .shift17(cmd.shift17),
        .a(ma), .b(mb), .done(mdone), .q(mq)
    );

    assign stat = '{cmd: c_reg, mass_nz: imass_reg != '0, iner_nz: iiner_reg != '0,
                    mul_done: mdone};

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LATCH) begin
            c_reg  <= in_cmd;
            vx_reg <= s_data[35:4];
            vy_reg <= s_data[67:36];
            px_reg <= s_data[99:68];
            py_reg <= s_data[131:100];
            sc_reg <= s_data[163:132];
        end
        if (cmd.op == OP_R) begin
            rx_reg <= sat_sub(px_reg, pos_reg[0]);
            ry_reg <= sat_sub(py_reg, pos_reg[1]);
        end
        if (mdone) begin
            unique case (cmd.dst)
                D_T0:   t0_reg <= mq;
                D_ACCX: acc_reg[0] <= gen_reg ? sat_add(mq, gx_reg) : mq;
                D_ACCY: acc_reg[1] <= gen_reg ? sat_add(mq, gy_reg) : mq;
                D_ACCA: acc_reg[2] <= mq;
                D_KX:   k_reg[0] <= mq;
                D_KY:   k_reg[1] <= mq;
                D_KA:   k_reg[2] <= mq;
                default: ;
            endcase
        end
        if (cmd.op == OP_TORQ_SUM) torq_reg <= sat_sub(t0_reg, mq);
        if (cmd.out_load) begin
            out_reg <= {vel_reg[2], vel_reg[1], vel_reg[0], pos_reg[2], pos_reg[1], pos_reg[0]};
        end
        if (!aresetn) begin
            imass_reg <= '0; iiner_reg <= '0; gen_reg <= 1'b0;
            gx_reg <= '0; gy_reg <= '0; ww_reg <= '0; wh_reg <= '0;
            fx_reg <= '0; fy_reg <= '0; mom_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0; vel_reg[i] <= '0; pini_reg[i] <= '0; vini_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                priority case (cfg_index)
                    REG_INV_MASS:    imass_reg <= cfg_data[30:0];
                    REG_INV_INERTIA: iiner_reg <= cfg_data[30:0];
                    REG_GRAV_EN:     gen_reg   <= cfg_data[0];
                    REG_GRAV_X:      gx_reg    <= cfg_data;
                    REG_GRAV_Y:      gy_reg    <= cfg_data;
                    REG_WORLD_W:     ww_reg    <= cfg_data[30:0];
                    REG_WORLD_H:     wh_reg    <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_SIMPLE) begin
                priority case (c_reg)
                    CMD_FORCE: if (imass_reg != '0) begin
                        fx_reg <= sat_add(fx_reg, vx_reg);
                        fy_reg <= sat_add(fy_reg, vy_reg);
                    end
                    CMD_TORQUE: if (iiner_reg != '0) mom_reg <= sat_add(mom_reg, sc_reg);
                    CMD_INIT_POSE: begin
                        pini_reg[0] <= vx_reg; pini_reg[1] <= vy_reg; pini_reg[2] <= sc_reg;
                        pos_reg[0]  <= vx_reg; pos_reg[1]  <= vy_reg; pos_reg[2]  <= sc_reg;
                    end
                    CMD_INIT_VEL: begin
                        vini_reg[0] <= vx_reg; vini_reg[1] <= vy_reg; vini_reg[2] <= sc_reg;
                        vel_reg[0]  <= vx_reg; vel_reg[1]  <= vy_reg; vel_reg[2]  <= sc_reg;
                    end
                    CMD_RESET: begin
                        for (int i = 0; i < 3; i++) begin
                            pos_reg[i] <= pini_reg[i];
                            vel_reg[i] <= vini_reg[i];
                        end
                        fx_reg <= '0; fy_reg <= '0; mom_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.op == OP_R && c_reg == CMD_FORCE_AT && imass_reg != '0) begin
                fx_reg <= sat_add(fx_reg, vx_reg);
                fy_reg <= sat_add(fy_reg, vy_reg);
            end
            if (cmd.op == OP_TORQ_SUM && c_reg == CMD_FORCE_AT && iiner_reg != '0)
                mom_reg <= sat_add(mom_reg, sat_sub(t0_reg, mq));
            if (mdone) begin
                unique case (cmd.dst)
                    D_VX_ADD: vel_reg[0] <= sat_add(vel_reg[0], mq);
                    D_VY_ADD: vel_reg[1] <= sat_add(vel_reg[1], mq);
                    D_VA_ADD: vel_reg[2] <= sat_add(vel_reg[2], mq);
                    D_PX_ADD: pos_reg[0] <= sat_add(pos_reg[0], mq);
                    D_PY_ADD: pos_reg[1] <= sat_add(pos_reg[1], mq);
                    D_PA_ADD: pos_reg[2] <= sat_add(pos_reg[2], mq);
                    default: ;
                endcase
            end
            if (cmd.op == OP_KICK) begin
                for (int i = 0; i < 3; i++) vel_reg[i] <= sat_add(vel_reg[i], k_reg[i]);
            end
            if (cmd.op == OP_WALL) begin
                vel_reg[0] <= wall_vx;
                vel_reg[1] <= wall_vy;
                fx_reg <= '0; fy_reg <= '0; mom_reg <= '0;
            end
        end
    end

    assign m_data = out_reg;

    a_cmd_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_LATCH |=> c_reg == $past(in_cmd))
        else $error("command not captured");
    a_accum_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_WALL |=> fx_reg == 0 && fy_reg == 0 && mom_reg == 0)
        else $error("accumulators not cleared after step");
    a_dst_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mdone |-> $past(cmd.mul_go, 2))
        else $error("product without request");
endmodule
